// ===== hw/rtl/fms_pkg.sv =====
package fms_pkg;

  // flight phase
  typedef enum logic [3:0] {
    PH_DISCONNECTED = 4'd0,
    PH_READY        = 4'd1,
    PH_ARMING       = 4'd2,
    PH_DISARMING    = 4'd3,
    PH_TAKING_OFF   = 4'd4,
    PH_LEG1         = 4'd5,
    PH_LEG2         = 4'd6,
    PH_LEG3         = 4'd7,
    PH_LEG4         = 4'd8,
    PH_LANDING      = 4'd9,
    PH_COMPLETE     = 4'd10,
    PH_ABORTED      = 4'd11
  } phase_t;

  typedef enum logic [2:0] {
    OUT_ACCEPTED  = 3'd0,
    OUT_ABORT     = 3'd1,
    OUT_INVALID   = 3'd2,
    OUT_DUPLICATE = 3'd3,
    OUT_TERMINAL  = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_ARM      = 3'd1,
    CMD_DISARM   = 3'd2,
    CMD_TAKEOFF  = 3'd3,
    CMD_POSITION = 3'd4,
    CMD_LAND     = 3'd5
  } entry_cmd_t;

  typedef enum logic [1:0] {
    SCN_ARM_ONLY     = 2'd0,
    SCN_TAKEOFF_ONLY = 2'd1,
    SCN_SINGLE_LEG   = 2'd2,
    SCN_SQUARE       = 2'd3
  } scenario_t;

  // mission event codes
  localparam logic [4:0] EV_TELEM_CONNECTED    = 5'd1;
  localparam logic [4:0] EV_TELEM_DISCONNECTED = 5'd2;
  localparam logic [4:0] EV_VEHICLE_READY      = 5'd3;
  localparam logic [4:0] EV_ARM_REQ            = 5'd4;
  localparam logic [4:0] EV_ARM_ACC            = 5'd5;
  localparam logic [4:0] EV_ARM_REJ            = 5'd6;
  localparam logic [4:0] EV_ARMED              = 5'd7;
  localparam logic [4:0] EV_DISARM_REQ         = 5'd8;
  localparam logic [4:0] EV_DISARM_ACC         = 5'd9;
  localparam logic [4:0] EV_DISARM_REJ         = 5'd10;
  localparam logic [4:0] EV_DISARMED           = 5'd11;
  localparam logic [4:0] EV_TAKEOFF_REQ        = 5'd12;
  localparam logic [4:0] EV_TAKEOFF_ACC        = 5'd13;
  localparam logic [4:0] EV_TAKEOFF_REJ        = 5'd14;
  localparam logic [4:0] EV_TAKEOFF_ALT        = 5'd15;
  localparam logic [4:0] EV_POS_REQ            = 5'd16;
  localparam logic [4:0] EV_POS_ACC            = 5'd17;
  localparam logic [4:0] EV_POS_REJ            = 5'd18;
  localparam logic [4:0] EV_LEG_REACHED        = 5'd19;
  localparam logic [4:0] EV_LAND_REQ           = 5'd20;
  localparam logic [4:0] EV_LAND_ACC           = 5'd21;
  localparam logic [4:0] EV_LAND_REJ           = 5'd22;
  localparam logic [4:0] EV_LANDED             = 5'd23;
  localparam logic [4:0] EV_TIMEOUT            = 5'd24;
  localparam logic [4:0] EV_STALE_TELEM        = 5'd25;
  localparam logic [4:0] EV_INVALID_TELEM      = 5'd26;
  localparam logic [4:0] EV_COMMAND_FAILED     = 5'd27;
  localparam logic [4:0] EV_ABORT_REQ          = 5'd28;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 120;

  // sequencer state seen by the decoder
  typedef struct packed {
    phase_t     phase;
    logic [4:0] last_code;
    phase_t     last_code_phase;
    logic       last_valid;
  } seq_state_t;

  // decode result for one event
  typedef struct packed {
    phase_t     prior;
    phase_t     next;
    outcome_t   outcome;
    logic       acc;
    logic       term;
    entry_cmd_t cmd;
    logic [1:0] leg;
  } dec_t;

endpackage

// ===== hw/rtl/fms_decode.sv =====
module fms_decode (
  input  fms_pkg::seq_state_t st,
  input  fms_pkg::scenario_t  scenario,
  input  logic [4:0]          ev,
  output fms_pkg::dec_t       dec
);
  import fms_pkg::*;

  logic       is_abort;
  logic       is_stay;
  logic       tbl_hit;
  phase_t     tbl_next;
  phase_t     nxt;
  logic [3:0] leg_off;
  outcome_t   outc;
  logic       acc;
  logic       term;
  entry_cmd_t cmd;
  logic [1:0] leg;

  always_comb begin
    case (ev)
      EV_TELEM_DISCONNECTED, EV_ARM_REJ, EV_DISARM_REJ, EV_TAKEOFF_REJ,
      EV_POS_REJ, EV_LAND_REJ, EV_TIMEOUT, EV_STALE_TELEM, EV_INVALID_TELEM,
      EV_COMMAND_FAILED, EV_ABORT_REQ: is_abort = 1'b1;
      default: is_abort = 1'b0;
    endcase
  end

  // events a phase takes without moving
  always_comb begin
    case (st.phase)
      PH_READY:      is_stay = (ev == EV_VEHICLE_READY);
      PH_ARMING:     is_stay = (ev == EV_ARM_ACC);
      PH_DISARMING:  is_stay = (ev == EV_DISARM_REQ) || (ev == EV_DISARM_ACC);
      PH_TAKING_OFF: is_stay = (ev == EV_TAKEOFF_REQ) || (ev == EV_TAKEOFF_ACC);
      PH_LEG1, PH_LEG2, PH_LEG3, PH_LEG4:
        is_stay = (ev == EV_POS_REQ) || (ev == EV_POS_ACC);
      PH_LANDING:
        is_stay = (ev == EV_LAND_REQ) || (ev == EV_LAND_ACC) ||
                  (ev == EV_DISARM_REQ) || (ev == EV_DISARM_ACC);
      default:       is_stay = 1'b0;
    endcase
  end

  // transition table
  always_comb begin
    tbl_hit  = 1'b0;
    tbl_next = st.phase;
    case (st.phase)
      PH_DISCONNECTED: begin
        tbl_hit  = (ev == EV_TELEM_CONNECTED);
        tbl_next = PH_READY;
      end
      PH_READY: begin
        tbl_hit  = (ev == EV_ARM_REQ);
        tbl_next = PH_ARMING;
      end
      PH_ARMING: begin
        tbl_hit  = (ev == EV_ARMED);
        tbl_next = (scenario == SCN_ARM_ONLY) ? PH_DISARMING : PH_TAKING_OFF;
      end
      PH_DISARMING: begin
        tbl_hit  = (ev == EV_DISARMED);
        tbl_next = PH_COMPLETE;
      end
      PH_TAKING_OFF: begin
        tbl_hit  = (ev == EV_TAKEOFF_ALT);
        tbl_next = (scenario == SCN_TAKEOFF_ONLY) ? PH_LANDING : PH_LEG1;
      end
      PH_LEG1: begin
        tbl_hit  = (ev == EV_LEG_REACHED);
        tbl_next = (scenario == SCN_SINGLE_LEG) ? PH_LANDING : PH_LEG2;
      end
      PH_LEG2: begin
        tbl_hit  = (ev == EV_LEG_REACHED);
        tbl_next = PH_LEG3;
      end
      PH_LEG3: begin
        tbl_hit  = (ev == EV_LEG_REACHED);
        tbl_next = PH_LEG4;
      end
      PH_LEG4: begin
        tbl_hit  = (ev == EV_LEG_REACHED);
        tbl_next = PH_LANDING;
      end
      PH_LANDING: begin
        tbl_hit  = (ev == EV_LANDED);
        tbl_next = PH_COMPLETE;
      end
      default: begin
        tbl_hit  = 1'b0;
        tbl_next = st.phase;
      end
    endcase
  end

  // priority: terminal, duplicate, abort, stay, table
  always_comb begin
    nxt  = st.phase;
    outc = OUT_INVALID;
    acc  = 1'b0;
    if ((st.phase == PH_COMPLETE) || (st.phase == PH_ABORTED)) begin
      outc = OUT_TERMINAL;
    end else if (st.last_valid && (st.last_code == ev) &&
                 (st.last_code_phase == st.phase)) begin
      outc = OUT_DUPLICATE;
    end else if (is_abort) begin
      nxt  = PH_ABORTED;
      outc = OUT_ABORT;
      acc  = 1'b1;
    end else if (is_stay) begin
      outc = OUT_ACCEPTED;
      acc  = 1'b1;
    end else if (tbl_hit) begin
      nxt  = tbl_next;
      outc = OUT_ACCEPTED;
      acc  = 1'b1;
    end
  end

  assign leg_off = nxt - PH_LEG1;

  // entry action of the new phase
  always_comb begin
    leg = 2'd0;
    case (nxt)
      PH_ARMING:     cmd = CMD_ARM;
      PH_DISARMING:  cmd = CMD_DISARM;
      PH_TAKING_OFF: cmd = CMD_TAKEOFF;
      PH_LEG1, PH_LEG2, PH_LEG3, PH_LEG4: begin
        cmd = CMD_POSITION;
        leg = leg_off[1:0];
      end
      PH_LANDING:    cmd = CMD_LAND;
      default:       cmd = CMD_NONE;
    endcase
  end

  assign term = (nxt == PH_COMPLETE) || (nxt == PH_ABORTED);

  assign dec = '{prior: st.phase, next: nxt, outcome: outc, acc: acc, term: term,
                 cmd: cmd, leg: leg};

endmodule

// ===== hw/rtl/flight_mission_sequencer.sv =====
// channel   dir  handshake             payload
// in_       in   in_tvalid/in_tready   in_tdata: event, time, sequence
// out_      out  out_tvalid/out_tready out_tdata: phases, outcome, action, echoes
// cfg_      in   cfg_we (no wait)      cfg_wdata: scenario
//
// one request per cycle sustained unless out_tready stalls; path: input stage, output register
// the rate is set by the phase/last-event loop, which decodes and updates in the same cycle
// synchronous active-low reset: phase disconnected, no last event, scenario square
// a stalled output holds its result; the input stage still fills behind it
module flight_mission_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  // event [4:0], time [68:5], sequence [100:69], zero [103:101]
  input  logic [fms_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // prior [3:0], new [7:4], event [12:8], outcome [15:13], accepted [16],
  // terminal [17], entry cmd [20:18], entry leg [22:21], time [86:23],
  // sequence [118:87], zero [119]
  output logic [fms_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_wdata
);
  import fms_pkg::*;

  // input stage
  logic        s1_valid_r, s1_valid_nxt;
  logic [4:0]  s1_ev_r;
  logic [63:0] s1_time_r;
  logic [31:0] s1_seq_r;

  // output stage
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  // mission state
  seq_state_t st_r;
  scenario_t  scenario_r;
  dec_t       dec;

  logic in_acc;
  logic s1_go;

  // the input stage moves on when the output register is free or draining
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  fms_decode u_decode (
    .st       (st_r),
    .scenario (scenario_r),
    .ev       (s1_ev_r),
    .dec      (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ev_r   <= in_tdata[4:0];
      s1_time_r <= in_tdata[68:5];
      s1_seq_r  <= in_tdata[100:69];
    end
    if (s1_go) begin
      out_data_r <= {1'b0, s1_seq_r, s1_time_r, dec.leg, dec.cmd, dec.term,
                     dec.acc, dec.outcome, s1_ev_r, dec.next, dec.prior};
    end
  end

  // state moves only on an accepted event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase           <= PH_DISCONNECTED;
      st_r.last_code       <= 5'd0;
      st_r.last_code_phase <= PH_DISCONNECTED;
      st_r.last_valid      <= 1'b0;
    end else if (s1_go && dec.acc) begin
      st_r.phase           <= dec.next;
      st_r.last_code       <= s1_ev_r;
      st_r.last_code_phase <= dec.prior;
      st_r.last_valid      <= 1'b1;
    end
  end

  // scenario register; the user is to write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scenario_r <= SCN_SQUARE;
    end else if (cfg_we) begin
      scenario_r <= scenario_t'(cfg_wdata);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import fms_pkg::*;

  // event code zero has no name in the package; it never moves or aborts a mission
  localparam logic [4:0] EV_COMMAND_REQ = 5'd0;
  // generous bound: every request at the slowest sender gap and the sparsest ready pattern
  localparam int CYCLE_LIMIT = 400000;
  localparam int REQUEST_TARGET = 1850;
  localparam int ROUND_REQUESTS = 160;
  localparam int MAX_REPORTS = 40;

  // one mission event as it waits for the driver
  typedef struct packed {
    logic [4:0]  ev;
    logic [63:0] stamp;
    logic [31:0] seq;
  } mission_request_t;

  // one predicted sequencer response
  typedef struct packed {
    phase_t      prior_ph;
    phase_t      new_ph;
    logic [4:0]  ev;
    outcome_t    outcome;
    logic        acc;
    logic        term;
    entry_cmd_t  cmd;
    logic [1:0]  leg;
    logic [63:0] stamp;
    logic [31:0] seq;
  } mission_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_wdata = '0;

  // requests not yet on the bus, and responses the sequencer still owes
  mission_request_t pending_requests[$];
  mission_result_t  expected_results[$];

  // mirror of the sequencer state, advanced on every accepted request
  phase_t     cur_phase = PH_DISCONNECTED;
  logic [4:0] last_event = '0;
  phase_t     last_event_phase = PH_DISCONNECTED;
  bit         last_event_seen = 1'b0;
  scenario_t  scenario_sel = SCN_SQUARE;

  int queued_total = 0;
  int results_matched = 0;
  int error_count = 0;
  int cycle_count = 0;

  flight_mission_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // events that send any live mission straight to aborted
  function automatic bit aborts_mission(input logic [4:0] ev);
    case (ev)
      EV_TELEM_DISCONNECTED, EV_ARM_REJ, EV_DISARM_REJ, EV_TAKEOFF_REJ, EV_POS_REJ,
      EV_LAND_REJ, EV_TIMEOUT, EV_STALE_TELEM, EV_INVALID_TELEM, EV_COMMAND_FAILED,
      EV_ABORT_REQ: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // events a phase accepts without leaving it
  function automatic bit holds_phase(input phase_t ph, input logic [4:0] ev);
    case (ph)
      PH_READY:      return ev == EV_VEHICLE_READY;
      PH_ARMING:     return ev == EV_ARM_ACC;
      PH_DISARMING:  return ev == EV_DISARM_REQ || ev == EV_DISARM_ACC;
      PH_TAKING_OFF: return ev == EV_TAKEOFF_REQ || ev == EV_TAKEOFF_ACC;
      PH_LEG1, PH_LEG2, PH_LEG3, PH_LEG4:
        return ev == EV_POS_REQ || ev == EV_POS_ACC;
      PH_LANDING:
        return ev == EV_LAND_REQ || ev == EV_LAND_ACC ||
               ev == EV_DISARM_REQ || ev == EV_DISARM_ACC;
      default: return 1'b0;
    endcase
  endfunction

  // the event that carries a phase forward along the mission
  function automatic logic [4:0] closing_event(input phase_t ph);
    case (ph)
      PH_DISCONNECTED: return EV_TELEM_CONNECTED;
      PH_READY:        return EV_ARM_REQ;
      PH_ARMING:       return EV_ARMED;
      PH_DISARMING:    return EV_DISARMED;
      PH_TAKING_OFF:   return EV_TAKEOFF_ALT;
      PH_LEG1, PH_LEG2, PH_LEG3, PH_LEG4: return EV_LEG_REACHED;
      PH_LANDING:      return EV_LANDED;
      default:         return EV_COMMAND_REQ;
    endcase
  endfunction

  // random event that keeps the phase: half the time one the phase holds on
  function automatic logic [4:0] pick_idle_event(input phase_t ph);
    logic [4:0] ev;
    bit         want_hold;
    int         tries;
    want_hold = 1'($urandom_range(0, 1));
    for (tries = 0; tries < 64; tries++) begin
      ev = 5'($urandom_range(0, 31));
      if (!aborts_mission(ev) && ev != closing_event(ph) &&
          (!want_hold || holds_phase(ph, ev)))
        return ev;
    end
    return EV_COMMAND_REQ;
  endfunction

  function automatic logic [63:0] random_stamp();
    return {$urandom(), $urandom()};
  endfunction

  // predict the response to one accepted request and advance the mirror
  task automatic advance_mission(input mission_request_t req);
    mission_result_t r;
    phase_t          target;
    bit              moves;
    target = cur_phase;
    moves = 1'b0;
    // transition table, three branches depend on the scenario
    case (cur_phase)
      PH_DISCONNECTED: begin
        moves = req.ev == EV_TELEM_CONNECTED;
        target = PH_READY;
      end
      PH_READY: begin
        moves = req.ev == EV_ARM_REQ;
        target = PH_ARMING;
      end
      PH_ARMING: begin
        moves = req.ev == EV_ARMED;
        if (scenario_sel == SCN_ARM_ONLY) target = PH_DISARMING;
        else target = PH_TAKING_OFF;
      end
      PH_DISARMING: begin
        moves = req.ev == EV_DISARMED;
        target = PH_COMPLETE;
      end
      PH_TAKING_OFF: begin
        moves = req.ev == EV_TAKEOFF_ALT;
        if (scenario_sel == SCN_TAKEOFF_ONLY) target = PH_LANDING;
        else target = PH_LEG1;
      end
      PH_LEG1: begin
        moves = req.ev == EV_LEG_REACHED;
        if (scenario_sel == SCN_SINGLE_LEG) target = PH_LANDING;
        else target = PH_LEG2;
      end
      PH_LEG2: begin
        moves = req.ev == EV_LEG_REACHED;
        target = PH_LEG3;
      end
      PH_LEG3: begin
        moves = req.ev == EV_LEG_REACHED;
        target = PH_LEG4;
      end
      PH_LEG4: begin
        moves = req.ev == EV_LEG_REACHED;
        target = PH_LANDING;
      end
      PH_LANDING: begin
        moves = req.ev == EV_LANDED;
        target = PH_COMPLETE;
      end
      default: moves = 1'b0;
    endcase

    r.prior_ph = cur_phase;
    r.new_ph = cur_phase;
    r.ev = req.ev;
    r.outcome = OUT_INVALID;
    r.acc = 1'b0;
    // priority: terminal, duplicate, abort, hold, table
    if (cur_phase == PH_COMPLETE || cur_phase == PH_ABORTED) begin
      r.outcome = OUT_TERMINAL;
    end else if (last_event_seen && last_event == req.ev && last_event_phase == cur_phase) begin
      r.outcome = OUT_DUPLICATE;
    end else if (aborts_mission(req.ev)) begin
      r.new_ph = PH_ABORTED;
      r.outcome = OUT_ABORT;
      r.acc = 1'b1;
    end else if (holds_phase(cur_phase, req.ev)) begin
      r.outcome = OUT_ACCEPTED;
      r.acc = 1'b1;
    end else if (moves) begin
      r.new_ph = target;
      r.outcome = OUT_ACCEPTED;
      r.acc = 1'b1;
    end

    if (r.acc) begin
      last_event = req.ev;
      last_event_phase = cur_phase;
      last_event_seen = 1'b1;
      cur_phase = r.new_ph;
    end

    r.term = r.new_ph == PH_COMPLETE || r.new_ph == PH_ABORTED;
    r.leg = 2'd0;
    // entry action of the phase the mission lands in
    case (r.new_ph)
      PH_ARMING:     r.cmd = CMD_ARM;
      PH_DISARMING:  r.cmd = CMD_DISARM;
      PH_TAKING_OFF: r.cmd = CMD_TAKEOFF;
      PH_LEG1, PH_LEG2, PH_LEG3, PH_LEG4: begin
        r.cmd = CMD_POSITION;
        r.leg = 2'(r.new_ph - PH_LEG1);
      end
      PH_LANDING:    r.cmd = CMD_LAND;
      default:       r.cmd = CMD_NONE;
    endcase
    r.stamp = req.stamp;
    r.seq = req.seq;
    expected_results.push_back(r);
  endtask

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("error at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_error($sformatf("response %0d %s got %0h expected %0h",
                             results_matched, name, got, want));
  endtask

  task automatic queue_request(input logic [4:0] ev, input logic [63:0] stamp,
                               input logic [31:0] seq);
    mission_request_t req;
    req.ev = ev;
    req.stamp = stamp;
    req.seq = seq;
    pending_requests.push_back(req);
    queued_total++;
  endtask

  // every queued request has been answered and checked
  task automatic wait_for_drain();
    while (results_matched != queued_total) @(posedge clk);
  endtask

  // sequencer is idle here, so the mirror takes the new scenario at once
  task automatic write_scenario(input scenario_t s);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    scenario_sel = s;
  endtask

  // driver: bursts of requests with random gaps, held while the queue is empty
  mission_request_t on_bus;
  int burst_left = 1;
  int idle_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) advance_mission(on_bus);
      if (!in_tvalid || in_tready) begin
        if (idle_left > 0) begin
          idle_left--;
          in_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          on_bus = pending_requests.pop_front();
          // event [4:0], time [68:5], sequence [100:69], zero pad above
          in_tdata <= {3'b000, on_bus.seq, on_bus.stamp, on_bus.ev};
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: a 16-bit ready pattern, redrawn each time the 6-bit tick wraps
  logic [15:0] ready_pattern = 16'hffff;
  logic [5:0]  ready_tick = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else begin
      if (ready_tick == 6'd0) begin
        case ($urandom_range(0, 3))
          0: ready_pattern = 16'hffff;
          1: ready_pattern = 16'($urandom());
          2: ready_pattern = 16'h0101;
          default: ready_pattern = 16'hf0f0 | 16'($urandom_range(0, 16'hffff));
        endcase
      end
      out_tready <= ready_pattern[ready_tick[3:0]];
      ready_tick <= ready_tick + 6'd1;
    end
  end

  // monitor: every response against the oldest prediction
  always @(posedge clk) begin
    mission_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_error($sformatf("response with nothing expected, data %0h", out_tdata));
      end else begin
        want = expected_results.pop_front();
        check_field("prior_phase", 64'(out_tdata[3:0]), 64'(want.prior_ph));
        check_field("new_phase", 64'(out_tdata[7:4]), 64'(want.new_ph));
        check_field("event_echo", 64'(out_tdata[12:8]), 64'(want.ev));
        check_field("outcome", 64'(out_tdata[15:13]), 64'(want.outcome));
        check_field("was_accepted", 64'(out_tdata[16]), 64'(want.acc));
        check_field("is_terminal", 64'(out_tdata[17]), 64'(want.term));
        check_field("entry_cmd", 64'(out_tdata[20:18]), 64'(want.cmd));
        check_field("entry_leg", 64'(out_tdata[22:21]), 64'(want.leg));
        check_field("time_echo", out_tdata[86:23], want.stamp);
        check_field("seq_echo", 64'(out_tdata[118:87]), 64'(want.seq));
        results_matched++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int         code;
    int         n;
    int         fill;
    logic [4:0] ev;
    bit         first_round;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    write_scenario(SCN_ARM_ONLY);

    // directed: field extremes, every non-aborting code refused while disconnected,
    // unassigned codes, connect, a hold event and its duplicate
    queue_request(EV_COMMAND_REQ, 64'd0, 32'd0);
    queue_request(5'd31, {64{1'b1}}, {32{1'b1}});
    for (code = 1; code < 31; code++) begin
      if (!aborts_mission(5'(code)) && 5'(code) != EV_TELEM_CONNECTED)
        queue_request(5'(code), random_stamp(), $urandom());
    end
    queue_request(EV_TELEM_CONNECTED, random_stamp(), $urandom());
    queue_request(EV_VEHICLE_READY, random_stamp(), $urandom());
    queue_request(EV_VEHICLE_READY, random_stamp(), $urandom());

    // one round per mission phase: random traffic that keeps the phase,
    // then the event that moves on; the scenario is redrawn between rounds
    first_round = 1'b1;
    forever begin
      wait_for_drain();
      repeat (2) @(posedge clk);
      if (cur_phase == PH_COMPLETE || cur_phase == PH_ABORTED) break;
      if (first_round) write_scenario(SCN_SQUARE);
      else write_scenario(scenario_t'($urandom_range(0, 3)));
      first_round = 1'b0;
      for (n = 0; n < ROUND_REQUESTS; n++)
        queue_request(pick_idle_event(cur_phase), random_stamp(), $urandom());
      ev = closing_event(cur_phase);
      // last phase of the mission: finish normally or abort
      if ((cur_phase == PH_LANDING || cur_phase == PH_DISARMING) &&
          $urandom_range(0, 1) == 1) begin
        do ev = 5'($urandom_range(0, 31)); while (!aborts_mission(ev));
      end
      queue_request(ev, random_stamp(), $urandom());
    end

    // mission over: everything from here on must come back terminal
    fill = (queued_total < REQUEST_TARGET - 150) ? REQUEST_TARGET - queued_total : 150;
    for (n = 0; n < fill; n++)
      queue_request(5'($urandom_range(0, 31)), random_stamp(), $urandom());

    wait_for_drain();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      report_error($sformatf("%0d responses never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fms_pkg.sv
hw/rtl/fms_decode.sv
hw/rtl/flight_mission_sequencer.sv
sim/tb.sv
